// ===== hdl/permutation_cycle_decompose_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the permutation cycle decomposer
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_CYCLE_DECOMPOSE_ASSERT_SVH
`define PERMUTATION_CYCLE_DECOMPOSE_ASSERT_SVH

// same-cycle implication
`define PCD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pcd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcd_pkg
// Field widths and result status codes of the permutation cycle decomposer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcd_pkg;

    localparam int ELEM_W   = 8;   // loaded value
    localparam int CELEM_W  = 5;   // emitted index
    localparam int STAT_W   = 2;
    localparam int IDATA_W  = 8;
    localparam int ODATA_W  = 8;
    localparam int OUSER_W  = 3;

    typedef logic [STAT_W-1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_BAD_VAL  = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/pcd_bitmap.sv =====
// ----------------------------------------------------------------------------
// pcd_bitmap
// One flag per index: single-bit set, whole-map clear, one test port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcd_bitmap #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_clr,
    input  wire logic          i_set,
    input  wire logic [AW-1:0] i_set_addr,
    input  wire logic [AW-1:0] i_tst_addr,
    output logic               o_tst
);

    logic [DEPTH-1:0] r_map;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_map <= '0;
        end else if (i_set) begin
            r_map[i_set_addr] <= 1'b1;
        end
    end

    // addresses at or beyond DEPTH read as clear
    assign o_tst = (32'(i_tst_addr) < 32'(DEPTH)) ? r_map[i_tst_addr] : 1'b0;

endmodule

`default_nettype wire

// ===== hdl/permutation_cycle_decompose.sv =====
// Sequence: one element per load beat; after the final beat, each element is read, then
//   range and duplicate tested; the scan then finds each unvisited start and the walk
//   reads, then emits, each index. Sequential: no new set is taken until the last result
//   is registered; output stalls hold the walk. Read states serve the registered value store.
// Errors: a single result beat, with tlast set, in place of the walk.
// Reset: synchronous, active low; clears sequencer, element count, overflow, both flag maps.
`timescale 1ns / 1ps
`default_nettype none

// ----------------------------------------------------------------------------
// permutation_cycle_decompose
// Loads a permutation one beat per element, validates it and emits its cycles or an error beat.
// ----------------------------------------------------------------------------
module permutation_cycle_decompose #(
    parameter int MAX_LEN = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // slave side
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [pcd_pkg::IDATA_W-1:0]   i_s_axis_tdata,  // [7:0] element_value
    input  wire logic                          i_s_axis_tlast,  // is_final
    // master side
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [pcd_pkg::ODATA_W-1:0]        o_m_axis_tdata,  // [4:0] cycle_element, [7:5] 0
    output logic [pcd_pkg::OUSER_W-1:0]        o_m_axis_tuser,  // [0] closes_cycle, [2:1] status
    output logic                               o_m_axis_tlast   // run_last
);

    import pcd_pkg::*;

    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;   // index width
    localparam int CW = $clog2(MAX_LEN + 1);                    // count width

    // sequencer states
    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_CHK_RD = 3'd1;  // read stored value
    localparam logic [2:0] S_CHK_TS = 3'd2;  // range + duplicate test
    localparam logic [2:0] S_ERR    = 3'd3;  // single error beat
    localparam logic [2:0] S_SCAN   = 3'd4;  // find next unvisited start
    localparam logic [2:0] S_W_RD   = 3'd5;  // read image of current index
    localparam logic [2:0] S_W_EMIT = 3'd6;  // emit current index

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;    // elements held
    logic          r_ovf,   n_ovf;
    logic [CW-1:0] r_len,   n_len;
    logic [IW-1:0] r_idx,   n_idx;      // check index
    logic [IW-1:0] r_i,     n_i;        // outer scan index
    logic [IW-1:0] r_j,     n_j;        // walk index
    logic [CW-1:0] r_emit,  n_emit;     // results emitted in this set
    t_status       r_err,   n_err;

    // value store: written during load, read at one address per cycle
    logic [ELEM_W-1:0] r_mem [MAX_LEN];
    logic [ELEM_W-1:0] r_rdata;
    logic [IW-1:0]     rd_addr;
    logic              mem_we;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [CELEM_W-1:0]  r_out_elem,  n_out_elem;
    logic                r_out_close, n_out_close;
    t_status             r_out_stat,  n_out_stat;
    logic                r_out_last,  n_out_last;
    logic                out_free;

    // flag maps
    logic          clr_maps;
    logic          seen_set, seen_hit;
    logic          vis_set,  vis_hit;
    logic [IW-1:0] vis_tst_addr;

    logic          s_beat;
    logic [IW-1:0] nxt;
    logic          in_range;
    logic          closes;
    logic          is_last;
    logic          emit_now;

    assign s_beat   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign nxt      = r_rdata[IW-1:0];
    assign in_range = r_rdata < ELEM_W'(r_len);
    // the visited mark of the current index is registered, so nxt == r_j is what closes a self-loop
    assign closes   = vis_hit || (nxt == r_j);
    assign is_last  = (r_emit == r_len - CW'(1));
    assign emit_now = (r_state == S_W_EMIT) && out_free;
    assign mem_we   = s_beat && (r_count < CW'(MAX_LEN));
    assign rd_addr  = (r_state == S_CHK_RD) ? r_idx : r_j;
    assign vis_tst_addr = (r_state == S_SCAN) ? r_i : nxt;

    pcd_bitmap #(.DEPTH(MAX_LEN), .AW(IW)) u_seen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (clr_maps),
        .i_set      (seen_set),
        .i_set_addr (r_rdata[IW-1:0]),
        .i_tst_addr (r_rdata[IW-1:0]),
        .o_tst      (seen_hit)
    );

    pcd_bitmap #(.DEPTH(MAX_LEN), .AW(IW)) u_visited (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (clr_maps),
        .i_set      (vis_set),
        .i_set_addr (r_j),
        .i_tst_addr (vis_tst_addr),
        .o_tst      (vis_hit)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[IW-1:0]] <= i_s_axis_tdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_len       = r_len;
        n_idx       = r_idx;
        n_i         = r_i;
        n_j         = r_j;
        n_emit      = r_emit;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_elem  = r_out_elem;
        n_out_close = r_out_close;
        n_out_stat  = r_out_stat;
        n_out_last  = r_out_last;
        clr_maps    = 1'b0;
        seen_set    = 1'b0;
        vis_set     = 1'b0;

        case (r_state)
            S_LOAD: begin
                if (s_beat) begin
                    if (r_count < CW'(MAX_LEN)) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        if (r_ovf || (r_count == CW'(MAX_LEN))) begin
                            n_err   = ST_OVERFLOW;
                            n_state = S_ERR;
                        end else begin
                            n_len   = r_count + CW'(1);
                            n_idx   = '0;
                            n_state = S_CHK_RD;
                        end
                    end
                end
            end
            S_CHK_RD: begin
                n_state = S_CHK_TS;
            end
            S_CHK_TS: begin
                if (!in_range || seen_hit) begin
                    n_err   = ST_BAD_VAL;
                    n_state = S_ERR;
                end else begin
                    seen_set = 1'b1;
                    if (CW'(r_idx) == r_len - CW'(1)) begin
                        n_i     = '0;
                        n_emit  = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_CHK_RD;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_elem  = '0;
                    n_out_close = 1'b0;
                    n_out_stat  = r_err;
                    n_out_last  = 1'b1;
                    clr_maps    = 1'b1;
                    n_count     = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_LOAD;
                end
            end
            S_SCAN: begin
                if (vis_hit) begin
                    n_i = r_i + IW'(1);
                end else begin
                    n_j     = r_i;
                    n_state = S_W_RD;
                end
            end
            S_W_RD: begin
                n_state = S_W_EMIT;
            end
            S_W_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_elem  = CELEM_W'(r_j);
                    n_out_close = closes;
                    n_out_stat  = ST_OK;
                    n_out_last  = is_last;
                    vis_set     = 1'b1;
                    n_emit      = r_emit + CW'(1);
                    if (is_last) begin
                        clr_maps = 1'b1;
                        n_count  = '0;
                        n_ovf    = 1'b0;
                        n_state  = S_LOAD;
                    end else if (closes) begin
                        n_state = S_SCAN;
                    end else begin
                        n_j     = nxt;
                        n_state = S_W_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len       <= n_len;
        r_idx       <= n_idx;
        r_i         <= n_i;
        r_j         <= n_j;
        r_emit      <= n_emit;
        r_err       <= n_err;
        r_out_elem  <= n_out_elem;
        r_out_close <= n_out_close;
        r_out_stat  <= n_out_stat;
        r_out_last  <= n_out_last;
    end

    assign o_s_axis_tready = (r_state == S_LOAD);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = ODATA_W'(r_out_elem);
    assign o_m_axis_tuser  = {r_out_stat, r_out_close};
    assign o_m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
`include "permutation_cycle_decompose_assert.svh"

    // an error result always ends its run
    `PCD_ASSERT_NOW(a_err_is_last, r_out_valid && r_out_stat != ST_OK, r_out_last, "no tlast")
    // the walk never emits more indices than the set holds
    `PCD_ASSERT_NOW(a_emit_bound, r_state == S_W_EMIT, r_emit < r_len, "emit past set")
    // walk index stays inside the loaded set
    `PCD_ASSERT_NOW(a_walk_in_set, r_state == S_W_RD, CW'(r_j) < r_len, "walk index outside set")
    // once the last result is registered, the block is back to loading
    `PCD_ASSERT_NEXT(a_last_to_load, emit_now && is_last, r_state == S_LOAD, "no return to load")

endmodule

`default_nettype wire

// ===== tb/permutation_cycle_decompose_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_cycle_decompose_tb
// Streams permutation sets into the decomposer and checks every result beat
// against an in-bench cycle walker or a typed-in result. A short directed
// table covers the corner cases, long sets hit the size limits, then random
// sets run under several sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module permutation_cycle_decompose_tb;

    import pcd_pkg::*;

    localparam int MAX_LEN         = 32;
    localparam int ITEMS_PER_PHASE = 68;
    localparam int DRAIN_CYCLES    = 6 * MAX_LEN + 16;   // longest check + walk of a set
    localparam int CYCLE_LIMIT     = 400000;
    localparam int NUM_PHASES      = 5;

    // idling per phase: none, sender, receiver, both, none
    localparam int SEND_GAP_PCT [NUM_PHASES] = '{0, 70, 0, 16, 0};
    localparam int STALL_PCT    [NUM_PHASES] = '{0, 0, 70, 16, 0};

    // one result beat as the bench sees it
    typedef struct packed {
        logic [4:0] cycle_element;
        logic       closes_cycle;
        t_status    status;
        logic       run_last;
    } t_cycle_beat;

    typedef struct packed {
        logic [7:0]  value;
        logic        fin;
        logic        typed;     // 1: want holds the result, no prediction used
        t_cycle_beat want;
    } t_directed_row;

    typedef enum int {SET_VALID, SET_BAD, SET_OVERFLOW, SET_NOISE} t_set_kind;

    localparam int NUM_ROWS = 23;
    localparam t_directed_row DIRECTED_ROWS [NUM_ROWS] = '{
        // lone element right after reset: fixed point closing its own cycle
        '{8'd0,   1'b1, 1'b1, '{5'd0, 1'b1, ST_OK,      1'b1}},
        // top value in a one-element set is out of range
        '{8'd255, 1'b1, 1'b1, '{5'd0, 1'b0, ST_BAD_VAL, 1'b1}},
        // swap
        '{8'd1,   1'b0, 1'b0, '0},
        '{8'd0,   1'b1, 1'b0, '0},
        // repeated value
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b1, 1'b1, '{5'd0, 1'b0, ST_BAD_VAL, 1'b1}},
        // value equal to the set length
        '{8'd2,   1'b0, 1'b0, '0},
        '{8'd0,   1'b1, 1'b1, '{5'd0, 1'b0, ST_BAD_VAL, 1'b1}},
        // a single orbit (0 2 1)
        '{8'd2,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd1,   1'b1, 1'b0, '0},
        // fixed points around a swap: (0)(1 3)(2)
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd3,   1'b0, 1'b0, '0},
        '{8'd2,   1'b0, 1'b0, '0},
        '{8'd1,   1'b1, 1'b0, '0},
        // msb set after a good element
        '{8'd1,   1'b0, 1'b0, '0},
        '{8'd128, 1'b1, 1'b1, '{5'd0, 1'b0, ST_BAD_VAL, 1'b1}},
        // rotation, a single orbit (0 1 2 3)
        '{8'd1,   1'b0, 1'b0, '0},
        '{8'd2,   1'b0, 1'b0, '0},
        '{8'd3,   1'b0, 1'b0, '0},
        '{8'd0,   1'b1, 1'b0, '0},
        // alternating bit patterns
        '{8'h55,  1'b0, 1'b0, '0},
        '{8'hAA,  1'b1, 1'b1, '{5'd0, 1'b0, ST_BAD_VAL, 1'b1}}
    };

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [IDATA_W-1:0]   i_s_axis_tdata  = '0;    // [7:0] element_value
    logic                 i_s_axis_tlast  = 1'b0;  // is_final
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [ODATA_W-1:0]   o_m_axis_tdata;          // [4:0] cycle_element, [7:5] 0
    logic [OUSER_W-1:0]   o_m_axis_tuser;          // [0] closes_cycle, [2:1] status
    logic                 o_m_axis_tlast;          // run_last

    permutation_cycle_decompose #(
        .MAX_LEN (MAX_LEN)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_cycle_beat  cycle_beats_due [$];   // results still owed by the DUT, oldest first
    t_cycle_beat  fresh_q [$];           // results caused by the last accepted beat
    t_cycle_beat  want;

    // predictor copy of the load state
    logic [7:0]   held_values [MAX_LEN];
    int           held_count    = 0;
    bit           held_overflow = 1'b0;

    logic [7:0]   set_vals [64];         // set being sent

    int           send_gap_pct  = 0;
    int           stall_pct     = 0;
    int           fail_count    = 0;
    int           beats_sent    = 0;
    int           beats_checked = 0;
    int           sets_sent     = 0;
    int           kind_count [4] = '{0, 0, 0, 0};
    int unsigned  cycle_count   = 0;

    // ------------------------------------------------------------------------
    // Clock, cycle counter, watchdog
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
                 cycle_beats_due.size());
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor: stores one element; on the final one it validates the set and
    // walks its cycles from the smallest unvisited index. Fills fresh_q.
    // ------------------------------------------------------------------------
    task automatic decompose_beat(input logic [7:0] value, input logic fin);
        bit          seen    [MAX_LEN];
        bit          visited [MAX_LEN];
        int          len;
        int          j;
        int          nxt;
        bit          ok;
        t_cycle_beat b;
        fresh_q.delete();
        if (held_count < MAX_LEN) begin
            held_values[held_count] = value;
            held_count++;
        end else begin
            held_overflow = 1'b1;
        end
        if (!fin) return;

        len = held_count;
        if (held_overflow) begin
            // overflow wins over any value error
            fresh_q.push_back('{5'd0, 1'b0, ST_OVERFLOW, 1'b1});
        end else begin
            ok = 1'b1;
            for (int i = 0; i < len && ok; i++) begin
                if (held_values[i] >= len || seen[held_values[i]]) ok = 1'b0;
                else seen[held_values[i]] = 1'b1;
            end
            if (!ok) begin
                fresh_q.push_back('{5'd0, 1'b0, ST_BAD_VAL, 1'b1});
            end else begin
                for (int i = 0; i < len; i++) begin
                    j = i;
                    while (!visited[j]) begin
                        visited[j]      = 1'b1;
                        nxt             = held_values[j];
                        b.cycle_element = j[4:0];
                        b.closes_cycle  = visited[nxt];
                        b.status        = ST_OK;
                        b.run_last      = 1'b0;
                        fresh_q.push_back(b);
                        j = nxt;
                    end
                end
                fresh_q[fresh_q.size()-1].run_last = 1'b1;
            end
        end
        held_count    = 0;
        held_overflow = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sender: random gaps, then hold the beat until accepted. Expected results
    // come from the predictor unless the caller types them in.
    // ------------------------------------------------------------------------
    task automatic push_beat(input logic [7:0] value, input logic fin,
                             input logic typed, input t_cycle_beat typed_want);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        i_s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        beats_sent++;
        decompose_beat(value, fin);
        if (typed) cycle_beats_due.push_back(typed_want);
        else foreach (fresh_q[n]) cycle_beats_due.push_back(fresh_q[n]);
    endtask

    task automatic send_set(input int len);
        for (int i = 0; i < len; i++) begin
            push_beat(set_vals[i], i == len - 1, 1'b0, '0);
        end
        sets_sent++;
    endtask

    // hold off the sender until the DUT has delivered everything owed
    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        while (cycle_beats_due.size() != 0) @(posedge i_clk);
    endtask

    // random set: mostly well-formed permutations, small ones favored
    task automatic build_set(output int len, output t_set_kind kind);
        int r;
        int k;
        int victim;
        int donor;
        logic [7:0] tmp;
        r = $urandom_range(99);
        if (r < 62)      kind = SET_VALID;
        else if (r < 80) kind = SET_BAD;
        else if (r < 88) kind = SET_OVERFLOW;
        else             kind = SET_NOISE;

        case (kind)
            SET_OVERFLOW: begin
                len = $urandom_range(40, MAX_LEN + 1);
                for (int i = 0; i < len; i++) set_vals[i] = 8'($urandom_range(255));
            end
            SET_NOISE: begin
                len = $urandom_range(4, 1);
                for (int i = 0; i < len; i++) set_vals[i] = 8'($urandom_range(255));
            end
            default: begin
                r = $urandom_range(99);
                if (r < 65)      len = $urandom_range(6, 1);
                else if (r < 88) len = $urandom_range(16, 7);
                else if (r < 95) len = $urandom_range(MAX_LEN - 1, 17);
                else             len = MAX_LEN;
                for (int i = 0; i < len; i++) set_vals[i] = 8'(i);
                for (int i = len - 1; i > 0; i--) begin
                    k           = $urandom_range(i);
                    tmp         = set_vals[i];
                    set_vals[i] = set_vals[k];
                    set_vals[k] = tmp;
                end
                if (kind == SET_BAD) begin
                    victim = $urandom_range(len - 1);
                    if (len > 1 && $urandom_range(1) == 1) begin
                        // duplicate another element's value
                        donor = $urandom_range(len - 1);
                        if (donor == victim) donor = (victim + 1) % len;
                        set_vals[victim] = set_vals[donor];
                    end else begin
                        set_vals[victim] = 8'($urandom_range(255, len));
                    end
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, checked on every accepted result beat
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (cycle_beats_due.size() == 0) begin
                $error("result beat with nothing owed: tdata %0h tuser %0h tlast %0b",
                       o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                fail_count++;
            end else begin
                want = cycle_beats_due.pop_front();
                beats_checked++;
                if (o_m_axis_tdata[4:0] !== want.cycle_element) begin
                    $error("cycle_element: expected %0d, got %0d",
                           want.cycle_element, o_m_axis_tdata[4:0]);
                    fail_count++;
                end
                if (o_m_axis_tuser[0] !== want.closes_cycle) begin
                    $error("closes_cycle: expected %0b, got %0b",
                           want.closes_cycle, o_m_axis_tuser[0]);
                    fail_count++;
                end
                if (o_m_axis_tuser[2:1] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_m_axis_tuser[2:1]);
                    fail_count++;
                end
                if (o_m_axis_tlast !== want.run_last) begin
                    $error("run_last: expected %0b, got %0b", want.run_last, o_m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int        len;
        int        phase_start;
        t_set_kind kind;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corner cases, no idling
        for (int r = 0; r < NUM_ROWS; r++) begin
            push_beat(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].fin,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        end

        // full-length identity and reversal, then an overflow set counting up from zero
        for (int i = 0; i < MAX_LEN; i++) set_vals[i] = 8'(i);
        send_set(MAX_LEN);
        for (int i = 0; i < MAX_LEN; i++) set_vals[i] = 8'(MAX_LEN - 1 - i);
        send_set(MAX_LEN);
        for (int i = 0; i <= MAX_LEN; i++) set_vals[i] = 8'(i);
        send_set(MAX_LEN + 1);
        wait_for_results();

        // random sets under each idling pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_gap_pct = SEND_GAP_PCT[p];
            stall_pct    = STALL_PCT[p];
            phase_start  = beats_sent;
            while (beats_sent < phase_start + ITEMS_PER_PHASE) begin
                build_set(len, kind);
                kind_count[kind]++;
                send_set(len);
                if ($urandom_range(11) == 0) wait_for_results();
            end
            wait_for_results();
        end

        i_s_axis_tvalid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d beats in %0d sets (random: %0d valid, %0d bad value,",
                 beats_sent, sets_sent, kind_count[SET_VALID], kind_count[SET_BAD]);
        $display("  %0d overflow, %0d noise); checked %0d result beats under no,",
                 kind_count[SET_OVERFLOW], kind_count[SET_NOISE], beats_checked);
        $display("  sender, receiver and mixed idling");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/pcd_pkg.sv
hdl/pcd_bitmap.sv
hdl/permutation_cycle_decompose.sv
tb/permutation_cycle_decompose_tb.sv
